### design/amsc_pkg.sv
// shared types and constants of the accelerometer magnitude step counter
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package amsc_pkg;

  localparam int unsigned AccelW   = 13;
  localparam int unsigned MagW     = 13;
  localparam int unsigned TotW     = 32;
  localparam int unsigned ThrW     = 13;
  localparam int unsigned DistW    = 16;
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned InDataW  = 40;
  localparam int unsigned OutDataW = 80;

  // request kinds carried in tuser
  localparam logic ReqSample   = 1'b0;
  localparam logic ReqEvaluate = 1'b1;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgIdxThreshold = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgIdxDistance  = 1'b1;

  typedef struct packed {
    logic                     is_eval;
    logic signed [AccelW-1:0] z;
    logic signed [AccelW-1:0] y;
    logic signed [AccelW-1:0] x;
  } amsc_req_t;

  typedef struct packed {
    logic [TotW-1:0] distance_total;
    logic [TotW-1:0] step_total;
    logic [MagW-1:0] magnitude;
    logic            step_detected;
  } amsc_res_t;

endpackage

`default_nettype wire

### design/accel_magnitude_step_counter_unit.sv
// top level of the accelerometer magnitude step counter: stream ports and settings
// depends on amsc_pkg, amsc_front, amsc_back
//
// Each input beat either stores one x,y,z reading into the averaging windows
// (tuser 0) or evaluates the averaged magnitude and step detection (tuser 1),
// and every beat gives exactly one output beat. In the back end a sample is a
// window write; an evaluation past warm-up runs a mean, square and accumulate
// pass for each of the three axes and then the bit-per-cycle square root,
// while a warm-up evaluation goes straight to the result. A two-entry
// queue in front and an output register let input and output stall on their own.
`timescale 1ns / 1ps
`default_nettype none

module accel_magnitude_step_counter_unit import amsc_pkg::*; #(
  parameter int unsigned WINDOW_DEPTH = 8,
  parameter int unsigned WARMUP_EVALS = 12
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                s_axis_tvalid,
  output logic                     s_axis_tready,
  // accel_x, accel_y, accel_z, zero pad
  input  wire logic [InDataW-1:0]  s_axis_tdata,
  // req_type
  input  wire logic                s_axis_tuser,
  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready,
  // step_detected, magnitude, step_total, distance_total, zero pad
  output logic [OutDataW-1:0]      m_axis_tdata,
  input  wire logic                cfg_valid_i,
  output logic                     cfg_ready_o,
  input  wire logic [CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i
);

  logic [ThrW-1:0]  thr_q;
  logic [DistW-1:0] dist_q;
  logic             req_valid;
  amsc_req_t        req;
  logic             req_ready;
  amsc_res_t        res;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q  <= ThrW'(4);
      dist_q <= DistW'(75);
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CfgIdxThreshold: thr_q  <= cfg_data_i[ThrW-1:0];
        CfgIdxDistance:  dist_q <= cfg_data_i[DistW-1:0];
        default: ;
      endcase
    end
  end

  amsc_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .req_valid_o   (req_valid),
    .req_o         (req),
    .req_ready_i   (req_ready)
  );

  amsc_back #(
    .WINDOW_DEPTH (WINDOW_DEPTH),
    .WARMUP_EVALS (WARMUP_EVALS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_valid),
    .req_i       (req),
    .req_ready_o (req_ready),
    .thr_i       (thr_q),
    .dist_i      (dist_q),
    .res_valid_o (m_axis_tvalid),
    .res_o       (res),
    .res_ready_i (m_axis_tready)
  );

  assign m_axis_tdata = OutDataW'(res);

endmodule

`default_nettype wire

### design/amsc_front.sv
// input side: takes beats, decodes the request kind and queues up to two requests
// depends on amsc_pkg
`timescale 1ns / 1ps
`default_nettype none

module amsc_front import amsc_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               s_axis_tvalid,
  output logic                    s_axis_tready,
  input  wire logic [InDataW-1:0] s_axis_tdata,
  input  wire logic               s_axis_tuser,
  output logic                    req_valid_o,
  output amsc_req_t               req_o,
  input  wire logic               req_ready_i
);

  amsc_req_t  queue_q [2];
  logic       wr_ptr_q;
  logic       rd_ptr_q;
  logic [1:0] cnt_q;
  logic       push;
  logic       pop;
  amsc_req_t  dec;

  always_comb begin
    dec.is_eval = (s_axis_tuser == ReqEvaluate);
    dec.x       = s_axis_tdata[AccelW-1:0];
    dec.y       = s_axis_tdata[2*AccelW-1:AccelW];
    dec.z       = s_axis_tdata[3*AccelW-1:2*AccelW];
  end

  assign s_axis_tready = (cnt_q != 2'd2);
  assign req_valid_o   = (cnt_q != 2'd0);
  assign req_o         = queue_q[rd_ptr_q];
  assign push          = s_axis_tvalid && s_axis_tready;
  assign pop           = req_valid_o && req_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) begin
      queue_q[wr_ptr_q] <= dec;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop)  rd_ptr_q <= ~rd_ptr_q;
      if (push && !pop)      cnt_q <= cnt_q + 2'd1;
      else if (pop && !push) cnt_q <= cnt_q - 2'd1;
    end
  end

endmodule

`default_nettype wire

### design/amsc_back.sv
// execution side: sample windows, running sums, means, square root and step totals
// depends on amsc_pkg
`timescale 1ns / 1ps
`default_nettype none

module amsc_back import amsc_pkg::*; #(
  parameter int unsigned WINDOW_DEPTH = 8,
  parameter int unsigned WARMUP_EVALS = 12
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             req_valid_i,
  input  amsc_req_t             req_i,
  output logic                  req_ready_o,
  input  wire logic [ThrW-1:0]  thr_i,
  input  wire logic [DistW-1:0] dist_i,
  output logic                  res_valid_o,
  output amsc_res_t             res_o,
  input  wire logic             res_ready_i
);

  localparam int unsigned DivL     = $clog2(WINDOW_DEPTH);
  localparam int unsigned SumW     = AccelW + DivL;
  localparam int unsigned DivShift = SumW + DivL;
  localparam int unsigned DivMulW  = SumW + 1;
  localparam int unsigned ProdW    = SumW + DivMulW;
  localparam logic [DivMulW-1:0] DivMul =
    DivMulW'(((64'd1 << DivShift) + 64'(WINDOW_DEPTH) - 64'd1) / 64'(WINDOW_DEPTH));
  localparam int unsigned AddrW    = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam logic [AddrW-1:0] LastAddr = AddrW'(WINDOW_DEPTH - 1);
  localparam int unsigned WarmW    = $clog2(WARMUP_EVALS + 2);
  localparam logic [WarmW-1:0] WarmDone = WarmW'(WARMUP_EVALS + 1);
  localparam int unsigned SqW      = 2 * AccelW - 1;
  localparam int unsigned SsW      = SqW + 1;

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StWr   = 3'd1;
  localparam logic [2:0] StMul  = 3'd2;
  localparam logic [2:0] StSq   = 3'd3;
  localparam logic [2:0] StAcc  = 3'd4;
  localparam logic [2:0] StRoot = 3'd5;
  localparam logic [2:0] StFin  = 3'd6;

  logic [2:0]               st_q;
  amsc_req_t                cur_q;
  logic [3*AccelW-1:0]      win_mem [WINDOW_DEPTH];
  logic [3*AccelW-1:0]      rd_q;
  logic [AddrW-1:0]         wp_q;
  logic                     wrapped_q;
  logic signed [SumW-1:0]   sum_q [3];
  logic signed [SumW-1:0]   sum_d [3];
  logic signed [AccelW-1:0] new_v [3];
  logic signed [AccelW-1:0] old_v [3];
  logic [1:0]               axis_q;
  logic [SumW-1:0]          abs_sum;
  logic [ProdW-1:0]         prod_q;
  logic [MagW-1:0]          mean_mag;
  logic [SqW-1:0]           sq_q;
  logic [SsW-1:0]           ss_d;
  logic [SsW-1:0]           rem_q;
  logic [SsW-1:0]           rem_d;
  logic [SsW-1:0]           root_q;
  logic [SsW-1:0]           root_d;
  logic [SsW-1:0]           bit_q;
  logic [SsW-1:0]           trial;
  logic [WarmW-1:0]         warm_q;
  logic [MagW-1:0]          mag_q;
  logic [MagW-1:0]          prev_q;
  logic [TotW-1:0]          steps_q;
  logic [TotW-1:0]          dist_q;
  logic                     detect;
  logic                     out_free;
  logic                     take;
  logic                     do_wr;
  logic                     do_fin;

  assign out_free    = !res_valid_o || res_ready_i;
  assign req_ready_o = (st_q == StIdle);
  assign take        = req_valid_i && req_ready_o;
  assign do_wr       = (st_q == StWr) && out_free;
  assign do_fin      = (st_q == StFin) && out_free;

  // window update, unwritten slots read as zero until the first wrap
  always_comb begin
    new_v[0] = cur_q.x;
    new_v[1] = cur_q.y;
    new_v[2] = cur_q.z;
    old_v[0] = wrapped_q ? rd_q[AccelW-1:0]          : '0;
    old_v[1] = wrapped_q ? rd_q[2*AccelW-1:AccelW]   : '0;
    old_v[2] = wrapped_q ? rd_q[3*AccelW-1:2*AccelW] : '0;
    for (int i = 0; i < 3; i++) begin
      sum_d[i] = sum_q[i] + SumW'(new_v[i]) - SumW'(old_v[i]);
    end
  end

  // mean by reciprocal multiply on the magnitude of the sum
  assign abs_sum  = sum_q[axis_q][SumW-1] ? SumW'(-sum_q[axis_q]) : SumW'(sum_q[axis_q]);
  assign mean_mag = prod_q[DivShift +: MagW];
  assign ss_d     = rem_q + SsW'(sq_q);

  // one bit of the square root per cycle
  always_comb begin
    trial = root_q + bit_q;
    if (rem_q >= trial) begin
      rem_d  = rem_q - trial;
      root_d = (root_q >> 1) + bit_q;
    end else begin
      rem_d  = rem_q;
      root_d = root_q >> 1;
    end
  end

  assign detect = (MagW+1)'(mag_q) > ((MagW+1)'(prev_q) + (MagW+1)'(thr_i));

  always_ff @(posedge clk_i) begin
    if (take) begin
      rd_q  <= win_mem[wp_q];
      cur_q <= req_i;
    end
    if (do_wr) begin
      win_mem[wp_q] <= {cur_q.z, cur_q.y, cur_q.x};
    end
    if (st_q == StMul) prod_q <= ProdW'(abs_sum) * ProdW'(DivMul);
    if (st_q == StSq)  sq_q   <= SqW'(mean_mag) * SqW'(mean_mag);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= StIdle;
      wp_q        <= '0;
      wrapped_q   <= 1'b0;
      sum_q       <= '{default: '0};
      axis_q      <= 2'd0;
      rem_q       <= '0;
      root_q      <= '0;
      bit_q       <= '0;
      warm_q      <= '0;
      mag_q       <= '0;
      prev_q      <= '0;
      steps_q     <= '0;
      dist_q      <= '0;
      res_valid_o <= 1'b0;
    end else begin
      res_valid_o <= do_wr || do_fin || (res_valid_o && !res_ready_i);
      unique case (st_q)
        StIdle: begin
          if (take) begin
            if (!req_i.is_eval) begin
              st_q <= StWr;
            end else if (warm_q != WarmDone) begin
              warm_q <= warm_q + WarmW'(1);
              mag_q  <= '0;
              st_q   <= StFin;
            end else begin
              axis_q <= 2'd0;
              rem_q  <= '0;
              st_q   <= StMul;
            end
          end
        end
        StWr: begin
          if (do_wr) begin
            sum_q       <= sum_d;
            wp_q        <= (wp_q == LastAddr) ? '0 : wp_q + AddrW'(1);
            if (wp_q == LastAddr) wrapped_q <= 1'b1;
            st_q        <= StIdle;
          end
        end
        StMul: st_q <= StSq;
        StSq:  st_q <= StAcc;
        StAcc: begin
          rem_q <= ss_d;
          if (axis_q == 2'd2) begin
            root_q <= '0;
            bit_q  <= SsW'(1) << (SsW - 2);
            st_q   <= StRoot;
          end else begin
            axis_q <= axis_q + 2'd1;
            st_q   <= StMul;
          end
        end
        StRoot: begin
          rem_q  <= rem_d;
          root_q <= root_d;
          bit_q  <= bit_q >> 2;
          if (bit_q[0]) begin
            mag_q <= root_d[MagW-1:0];
            st_q  <= StFin;
          end
        end
        StFin: begin
          if (do_fin) begin
            if (detect) begin
              steps_q <= steps_q + TotW'(1);
              dist_q  <= dist_q + TotW'(dist_i);
            end
            prev_q      <= mag_q;
            st_q        <= StIdle;
          end
        end
        default: st_q <= StIdle;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      res_o.step_detected  <= 1'b0;
      res_o.magnitude      <= '0;
      res_o.step_total     <= steps_q;
      res_o.distance_total <= dist_q;
    end else if (do_fin) begin
      res_o.step_detected  <= detect;
      res_o.magnitude      <= mag_q;
      res_o.step_total     <= detect ? steps_q + TotW'(1) : steps_q;
      res_o.distance_total <= detect ? dist_q + TotW'(dist_i) : dist_q;
    end
  end

endmodule

`default_nettype wire
